FILE: rtl/sphi_pkg.sv
// ----------------------------------------------------------------------------
// sphi_pkg
// Shared types and constants of the segment position and heading interpolator.
// ----------------------------------------------------------------------------
package sphi_pkg;

    localparam int SQB      = 42;
    localparam int SQ_RW    = 2 * SQB + 1;
    localparam int QB       = 48;
    localparam int DV_W     = SQB + 1;
    localparam int FRONT_ST = 17;
    localparam int TAIL_ST  = 6;
    localparam int NST      = FRONT_ST + SQB + 1 + QB + TAIL_ST;

    localparam logic [31:0] SCALE_RESET  = 32'd40075016;
    localparam logic [30:0] PI_HALF_Q30  = 31'd1686629713;
    localparam logic [30:0] Q30_ONE      = 31'd1073741824;
    localparam logic [47:0] FRAC_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [17:0] HEADING_FULL = 18'd46080;

    localparam logic [33:0] RECIP_M [4] = '{
        34'(((64'd1 << 39) + 64'd89) / 64'd90),
        34'(((64'd1 << 38) + 64'd55) / 64'd56),
        34'(((64'd1 << 37) + 64'd29) / 64'd30),
        34'(((64'd1 << 36) + 64'd11) / 64'd12)
    };
    localparam int RECIP_SH [4] = '{39, 38, 37, 36};

    typedef struct packed {
        logic signed [31:0] slat;
        logic signed [31:0] slon;
        logic signed [31:0] elat;
        logic signed [31:0] elon;
        logic [15:0]        ha;
        logic [15:0]        hb;
        logic [31:0]        trav;
        logic               met;
        logic               nlat;
        logic [32:0]        alat;
        logic               nlon;
        logic [32:0]        alon;
    } t_carry;

    typedef struct packed {
        logic [31:0] x2;
        logic [40:0] dy;
        logic [40:0] dxr;
    } t_side;

endpackage

FILE: rtl/segment_position_heading_interpolator_core.sv
// ----------------------------------------------------------------------------
// segment_position_heading_interpolator_core
// Segment length, travelled fraction, position and shortest-arc heading.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with one segment word per transfer.
//   Output channel: o_valid / i_stall with one result word per input word.
//   Config channel: i_cfg_valid / o_cfg_ready writes the metres-per-unit
//   scale; o_cfg_ready is always high. Write it only while the block is idle.
//   From input transfer to result on the outputs a word passes through
//   17 stages of cosine and squared length, 42 square-root stages (one root
//   bit each), one divider setup stage, 48 divider stages (one quotient bit
//   each) and 6 interpolation stages.
//   Throughput is one word per cycle unless a result is stalled; every stage holds one word.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   o_stall rises; nothing is lost or repeated.
//   Reset empties the pipeline and loads the scale with its default.
// ----------------------------------------------------------------------------
module segment_position_heading_interpolator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_start_lat,
    input  logic signed [31:0] i_start_lon,
    input  logic signed [31:0] i_end_lat,
    input  logic signed [31:0] i_end_lon,
    input  logic [15:0]        i_start_heading,
    input  logic [15:0]        i_end_heading,
    input  logic [31:0]        i_travelled,
    input  logic               i_to_metres,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pos_lat,
    output logic signed [31:0] o_pos_lon,
    output logic signed [31:0] o_heading,
    output logic               o_saturated
);
    import sphi_pkg::*;

    logic            w_en;
    logic [31:0]     r_scale;
    logic [NST-1:0]  r_vld;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_vld[NST-1];
    assign o_stall     = r_vld[NST-1] & i_stall;
    assign w_en        = ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_vld   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_scale <= i_cfg_data;
            end
            if (w_en) begin
                r_vld <= {r_vld[NST-2:0], i_valid};
            end
        end
    end

    // Stage 1: register the word, differences and mid latitude
    t_carry             r1_c;
    logic signed [32:0] r1_dlat, r1_dlon;
    logic [31:0]        r1_mid;
    logic signed [32:0] w1_mid;

    assign w1_mid = 33'(i_start_lat / 2) + 33'(i_end_lat / 2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_c.slat <= i_start_lat;
            r1_c.slon <= i_start_lon;
            r1_c.elat <= i_end_lat;
            r1_c.elon <= i_end_lon;
            r1_c.ha   <= i_start_heading;
            r1_c.hb   <= i_end_heading;
            r1_c.trav <= i_travelled;
            r1_c.met  <= i_to_metres;
            r1_c.nlat <= 1'b0;
            r1_c.alat <= '0;
            r1_c.nlon <= 1'b0;
            r1_c.alon <= '0;
            r1_dlat   <= 33'(i_end_lat) - 33'(i_start_lat);
            r1_dlon   <= 33'(i_end_lon) - 33'(i_start_lon);
            r1_mid    <= w1_mid[31:0];
        end
    end

    // Stage 2: magnitudes and folded cosine argument
    t_carry      r2_c, w2_c;
    logic [30:0] r2_r;

    always_comb begin
        w2_c      = r1_c;
        w2_c.nlat = r1_dlat[32];
        w2_c.alat = r1_dlat[32] ? 33'(-r1_dlat) : 33'(r1_dlat);
        w2_c.nlon = r1_dlon[32];
        w2_c.alon = r1_dlon[32] ? 33'(-r1_dlon) : 33'(r1_dlon);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_c <= w2_c;
            r2_r <= r1_mid[30] ? 31'(Q30_ONE) - 31'(r1_mid[29:0])
                               : 31'(r1_mid[29:0]);
        end
    end

    // Stage 3: angle in radians, scaled axis lengths
    t_carry      r3_c;
    t_side       r3_s;
    logic [30:0] r3_x;
    logic [61:0] w3_x;
    logic [64:0] w3_py, w3_px;

    assign w3_x  = 62'(r2_r) * 62'(PI_HALF_Q30);
    assign w3_py = 65'(r2_c.alat) * 65'(r_scale);
    assign w3_px = 65'(r2_c.alon) * 65'(r_scale);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_c       <= r2_c;
            r3_x       <= w3_x[60:30];
            r3_s.x2    <= '0;
            r3_s.dy    <= r2_c.met ? w3_py[64:24] : {r2_c.alat[32:0], 8'd0};
            r3_s.dxr   <= r2_c.met ? w3_px[64:24] : {r2_c.alon[32:0], 8'd0};
        end
    end

    // Stage 4 onwards: series for the cosine, one multiply per stage
    logic [31:0] r_fp_p [5];
    t_side       r_fp_s [5];
    t_carry      r_fp_c [5];
    logic [31:0] r_fq_q [4];
    t_side       r_fq_s [4];
    t_carry      r_fq_c [4];
    logic [61:0] w4_x2;

    assign w4_x2 = 62'(r3_x) * 62'(r3_x);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fp_p[0] <= w4_x2[61:30];
            r_fp_s[0] <= {w4_x2[61:30], r3_s.dy, r3_s.dxr};
            r_fp_c[0] <= r3_c;
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_cos
        localparam int SH = RECIP_SH[j];
        logic [65:0] w_q;
        logic [30:0] w_t;
        logic [63:0] w_p;

        assign w_q = 66'(r_fp_p[j]) * 66'(RECIP_M[j]);
        assign w_t = Q30_ONE - 31'(r_fq_q[j]);
        assign w_p = 64'(r_fq_s[j].x2) * 64'(w_t);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_fq_q[j]   <= w_q[SH+31:SH];
                r_fq_s[j]   <= r_fp_s[j];
                r_fq_c[j]   <= r_fp_c[j];
                r_fp_p[j+1] <= w_p[61:30];
                r_fp_s[j+1] <= r_fq_s[j];
                r_fp_c[j+1] <= r_fq_c[j];
            end
        end
    end

    // Stage 13: cosine magnitude in Q24
    t_carry      r13_c;
    t_side       r13_s;
    logic [24:0] r13_cos;
    logic [30:0] w13_p, w13_c;

    assign w13_p = r_fp_p[4][31:1];
    assign w13_c = (w13_p > Q30_ONE) ? 31'd0 : Q30_ONE - w13_p;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r13_c   <= r_fp_c[4];
            r13_s   <= r_fp_s[4];
            r13_cos <= w13_c[30:6];
        end
    end

    // Stage 14: east-west length
    t_carry      r14_c;
    logic [40:0] r14_dx, r14_dy;
    logic [65:0] w14_dx;

    assign w14_dx = 66'(r13_s.dxr) * 66'(r13_cos);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r14_c  <= r13_c;
            r14_dy <= r13_s.dy;
            r14_dx <= r13_c.met ? w14_dx[64:24] : r13_s.dxr;
        end
    end

    // Stages 15 and 16: squares from split partial products
    t_carry      r15_c;
    logic [39:0] r15_xhh, r15_yhh;
    logic [40:0] r15_xhl, r15_yhl;
    logic [41:0] r15_xll, r15_yll;
    t_carry      r16_c;
    logic [81:0] r16_sx, r16_sy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r15_c   <= r14_c;
            r15_xhh <= 40'(r14_dx[40:21]) * 40'(r14_dx[40:21]);
            r15_xhl <= 41'(r14_dx[40:21]) * 41'(r14_dx[20:0]);
            r15_xll <= 42'(r14_dx[20:0]) * 42'(r14_dx[20:0]);
            r15_yhh <= 40'(r14_dy[40:21]) * 40'(r14_dy[40:21]);
            r15_yhl <= 41'(r14_dy[40:21]) * 41'(r14_dy[20:0]);
            r15_yll <= 42'(r14_dy[20:0]) * 42'(r14_dy[20:0]);
            r16_c   <= r15_c;
            r16_sx  <= (82'(r15_xhh) << 42) + (82'(r15_xhl) << 22) + 82'(r15_xll);
            r16_sy  <= (82'(r15_yhh) << 42) + (82'(r15_yhl) << 22) + 82'(r15_yll);
        end
    end

    // Square root, one root bit per stage
    logic [SQ_RW-1:0] r_sq_rem [SQB+1];
    logic [SQB-1:0]   r_sq_res [SQB+1];
    t_carry           r_sq_c   [SQB+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_rem[0] <= SQ_RW'(r16_sx) + SQ_RW'(r16_sy);
            r_sq_res[0] <= '0;
            r_sq_c[0]   <= r16_c;
        end
    end

    for (genvar k = 0; k < SQB; k++) begin : g_sqrt
        localparam int BI = SQB - 1 - k;
        logic [SQ_RW-1:0] w_trial;
        logic             w_ge;

        assign w_trial = (SQ_RW'(r_sq_res[k]) << (BI + 1)) | (SQ_RW'(1) << (2 * BI));
        assign w_ge    = r_sq_rem[k] >= w_trial;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rem[k+1] <= w_ge ? r_sq_rem[k] - w_trial : r_sq_rem[k];
                r_sq_res[k+1] <= w_ge ? r_sq_res[k] | (SQB'(1) << BI) : r_sq_res[k];
                r_sq_c[k+1]   <= r_sq_c[k];
            end
        end
    end

    // Divider: setup then one quotient bit per stage
    logic [DV_W-1:0] r_dv_rem  [QB+1];
    logic [QB-1:0]   r_dv_q    [QB+1];
    logic [SQB-1:0]  r_dv_len  [QB+1];
    logic            r_dv_sat  [QB+1];
    logic            r_dv_zero [QB+1];
    t_carry          r_dv_c    [QB+1];
    logic [SQB-1:0]  w_len;

    assign w_len = r_sq_res[SQB];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_rem[0]  <= DV_W'(r_sq_c[SQB].trav[31:16]);
            r_dv_q[0]    <= '0;
            r_dv_len[0]  <= w_len;
            r_dv_zero[0] <= (w_len == '0);
            r_dv_sat[0]  <= (w_len != '0) &&
                            ((SQB + 16)'(r_sq_c[SQB].trav) >= {w_len, 16'd0});
            r_dv_c[0]    <= r_sq_c[SQB];
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        logic            w_bit;
        logic [DV_W-1:0] w_t;
        logic            w_ge;

        if (j < 16) begin : g_num
            assign w_bit = r_dv_c[j].trav[15-j];
        end else begin : g_zero
            assign w_bit = 1'b0;
        end

        assign w_t  = {r_dv_rem[j][DV_W-2:0], w_bit};
        assign w_ge = w_t >= DV_W'(r_dv_len[j]);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rem[j+1]  <= w_ge ? w_t - DV_W'(r_dv_len[j]) : w_t;
                r_dv_q[j+1]    <= {r_dv_q[j][QB-2:0], w_ge};
                r_dv_len[j+1]  <= r_dv_len[j];
                r_dv_sat[j+1]  <= r_dv_sat[j];
                r_dv_zero[j+1] <= r_dv_zero[j];
                r_dv_c[j+1]    <= r_dv_c[j];
            end
        end
    end

    // Fraction select and heading offset
    t_carry             r_f_c;
    logic [47:0]        r_f_frac;
    logic               r_f_sat, r_f_zero, r_f_offn;
    logic [15:0]        r_f_offm;
    logic signed [17:0] w_ha, w_hb, w_cw, w_ccw, w_off;

    assign w_ha = 18'(r_dv_c[QB].ha);
    assign w_hb = 18'(r_dv_c[QB].hb);

    always_comb begin
        priority if (w_ha < w_hb) begin
            w_cw  = w_hb - w_ha;
            w_ccw = $signed(HEADING_FULL) - w_hb + w_ha;
        end else if (w_ha > w_hb) begin
            w_cw  = $signed(HEADING_FULL) - w_ha + w_hb;
            w_ccw = w_ha - w_hb;
        end else begin
            w_cw  = '0;
            w_ccw = '0;
        end
        w_off = (w_cw < w_ccw) ? w_cw : -w_ccw;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_c    <= r_dv_c[QB];
            r_f_zero <= r_dv_zero[QB];
            r_f_sat  <= r_dv_sat[QB] & ~r_dv_zero[QB];
            r_f_frac <= r_dv_zero[QB] ? 48'd0 : (r_dv_sat[QB] ? FRAC_MAX : r_dv_q[QB]);
            r_f_offn <= w_off[17];
            r_f_offm <= w_off[17] ? 16'(-w_off) : 16'(w_off);
        end
    end

    // Interpolation stage 1: partial products
    t_carry      r_l1_c;
    logic        r_l1_sat, r_l1_offn;
    logic [48:0] r_l1_plh, r_l1_pnh;
    logic [64:0] r_l1_plf, r_l1_pnf;
    logic [31:0] r_l1_hh;
    logic [47:0] r_l1_hl;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l1_c    <= r_f_c;
            r_l1_sat  <= r_f_sat;
            r_l1_offn <= r_f_offn;
            r_l1_plh  <= 49'(r_f_c.alat) * 49'(r_f_frac[47:32]);
            r_l1_plf  <= 65'(r_f_c.alat) * 65'(r_f_frac[31:0]);
            r_l1_pnh  <= 49'(r_f_c.alon) * 49'(r_f_frac[47:32]);
            r_l1_pnf  <= 65'(r_f_c.alon) * 65'(r_f_frac[31:0]);
            r_l1_hh   <= 32'(r_f_offm) * 32'(r_f_frac[47:32]);
            r_l1_hl   <= 48'(r_f_offm) * 48'(r_f_frac[31:0]);
        end
    end

    // Interpolation stage 2: full products
    t_carry      r_l2_c;
    logic        r_l2_sat, r_l2_offn;
    logic [80:0] r_l2_plat, r_l2_plon;
    logic [63:0] r_l2_m;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l2_c    <= r_l1_c;
            r_l2_sat  <= r_l1_sat;
            r_l2_offn <= r_l1_offn;
            r_l2_plat <= (81'(r_l1_plh) << 32) + 81'(r_l1_plf);
            r_l2_plon <= (81'(r_l1_pnh) << 32) + 81'(r_l1_pnf);
            r_l2_m    <= (64'(r_l1_hh) << 32) + 64'(r_l1_hl);
        end
    end

    // Interpolation stage 3: position plus one half, rounded heading step
    t_carry      r_l3_c;
    logic        r_l3_sat, r_l3_offn;
    logic [83:0] r_l3_wlat, r_l3_wlon;
    logic [31:0] r_l3_sm;
    logic [83:0] w3_blat, w3_blon;
    logic [64:0] w3_m;

    assign w3_blat = {{20{r_l2_c.slat[31]}}, r_l2_c.slat, 32'h8000_0000};
    assign w3_blon = {{20{r_l2_c.slon[31]}}, r_l2_c.slon, 32'h8000_0000};
    assign w3_m    = 65'(r_l2_m) + (r_l2_offn ? 65'h7FFF_FFFF : 65'h8000_0000);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l3_c    <= r_l2_c;
            r_l3_sat  <= r_l2_sat;
            r_l3_offn <= r_l2_offn;
            r_l3_wlat <= r_l2_c.nlat ? w3_blat - 84'(r_l2_plat) : w3_blat + 84'(r_l2_plat);
            r_l3_wlon <= r_l2_c.nlon ? w3_blon - 84'(r_l2_plon) : w3_blon + 84'(r_l2_plon);
            r_l3_sm   <= w3_m[63:32];
        end
    end

    // Interpolation stage 4: truncate toward zero, add heading step
    logic        r_l4_sat;
    logic [51:0] r_l4_vlat, r_l4_vlon;
    logic [34:0] r_l4_hd;
    logic        w4_clat, w4_clon;

    assign w4_clat = r_l3_wlat[83] & (r_l3_wlat[31:0] != '0);
    assign w4_clon = r_l3_wlon[83] & (r_l3_wlon[31:0] != '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l4_sat  <= r_l3_sat;
            r_l4_vlat <= r_l3_wlat[83:32] + 52'(w4_clat);
            r_l4_vlon <= r_l3_wlon[83:32] + 52'(w4_clon);
            r_l4_hd   <= r_l3_offn ? 35'(r_l3_c.ha) - 35'(r_l3_sm)
                                   : 35'(r_l3_c.ha) + 35'(r_l3_sm);
        end
    end

    // Output stage: saturate position, wrap and clamp heading
    logic               w5_hi_lat, w5_lo_lat, w5_hi_lon, w5_lo_lon;
    logic signed [34:0] w5_hd;
    logic signed [34:0] w5_hw;

    assign w5_hi_lat = $signed(r_l4_vlat) > 52'sh7FFF_FFFF;
    assign w5_lo_lat = $signed(r_l4_vlat) < -52'sh8000_0000;
    assign w5_hi_lon = $signed(r_l4_vlon) > 52'sh7FFF_FFFF;
    assign w5_lo_lon = $signed(r_l4_vlon) < -52'sh8000_0000;
    assign w5_hd     = $signed(r_l4_hd);

    always_comb begin
        priority if (w5_hd > $signed(35'(HEADING_FULL))) begin
            w5_hw = w5_hd - $signed(35'(HEADING_FULL));
        end else if (w5_hd < 35'sd0) begin
            w5_hw = w5_hd + $signed(35'(HEADING_FULL));
        end else begin
            w5_hw = w5_hd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_pos_lat   <= w5_hi_lat ? 32'sh7FFF_FFFF :
                           (w5_lo_lat ? 32'sh8000_0000 : $signed(r_l4_vlat[31:0]));
            o_pos_lon   <= w5_hi_lon ? 32'sh7FFF_FFFF :
                           (w5_lo_lon ? 32'sh8000_0000 : $signed(r_l4_vlon[31:0]));
            o_heading   <= (w5_hw > 35'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                           ((w5_hw < -35'sh8000_0000) ? 32'sh8000_0000
                                                     : $signed(w5_hw[31:0]));
            o_saturated <= r_l4_sat | w5_hi_lat | w5_lo_lat | w5_hi_lon | w5_lo_lon;
        end
    end

`ifndef SYNTHESIS
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && w_en) |=> r_vld[0])
        else $error("accepted word did not enter the pipeline");

    a_frac_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_sat |-> (r_f_frac == FRAC_MAX) && !r_f_zero)
        else $error("saturated fraction not at its limit");
`endif

endmodule

FILE: bench/segment_position_heading_interpolator_core_tb.sv
// ----------------------------------------------------------------------------
// segment_position_heading_interpolator_core_tb
// Drives segment words with random gaps and output stalls, predicts each
// result from a bit-exact integer model and checks it field by field.
// ----------------------------------------------------------------------------
module segment_position_heading_interpolator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sphi_pkg::*;

    localparam int LATENCY  = 114;
    localparam int WD_LIMIT = 4000;
    localparam int N_RAND   = 1500;

    typedef struct packed {
        logic signed [31:0] slat;
        logic signed [31:0] slon;
        logic signed [31:0] elat;
        logic signed [31:0] elon;
        logic [15:0]        ha;
        logic [15:0]        hb;
        logic [31:0]        trav;
        logic               met;
    } seg_t;

    typedef struct packed {
        logic signed [31:0] lat;
        logic signed [31:0] lon;
        logic signed [31:0] hd;
        logic               sat;
    } interp_t;

    class interp_scoreboard;
        interp_t     pending[$];
        logic [31:0] scale;
        int          errors;
        int          seen;

        function new();
            scale  = SCALE_RESET;
            errors = 0;
            seen   = 0;
        endfunction

        function logic [63:0] cos_q24(logic signed [63:0] mid);
            logic [63:0] u, r, x, x2, t, p, c;
            u = mid & 64'hFFFF_FFFF;
            r = u & 64'h3FFF_FFFF;
            if (u[30]) r = 64'd1073741824 - r;
            x  = (r * 64'd1686629713) >> 30;
            x2 = (x * x) >> 30;
            t = 64'd1073741824 - x2 / 90;
            t = 64'd1073741824 - ((x2 * t) >> 30) / 56;
            t = 64'd1073741824 - ((x2 * t) >> 30) / 30;
            t = 64'd1073741824 - ((x2 * t) >> 30) / 12;
            p = ((x2 * t) >> 30) / 2;
            c = (p > 64'd1073741824) ? 64'd0 : 64'd1073741824 - p;
            return c >> 6;
        endfunction

        function logic signed [31:0] sat32(logic signed [127:0] v, ref logic s);
            if (v > 128'sd2147483647) begin
                s = 1'b1;
                return 32'sh7FFF_FFFF;
            end
            if (v < -128'sd2147483648) begin
                s = 1'b1;
                return 32'sh8000_0000;
            end
            return v[31:0];
        endfunction

        // exact a + d*f/2^32 + 1/2, truncated toward zero
        function logic signed [31:0] lerp(logic signed [31:0] a, logic signed [31:0] b,
                                          logic [63:0] f, ref logic s);
            logic signed [127:0] num, q, den;
            den = 128'sd1 <<< 33;
            num = ((128'(signed'(b)) - 128'(signed'(a))) * $signed({64'd0, f}) * 2)
                  + (128'(signed'(a)) <<< 33) + (128'sd1 <<< 32);
            q = num / den;
            return sat32(q, s);
        endfunction

        function interp_t predict(seg_t w);
            interp_t          o;
            logic [63:0]      alat, alon, dx, dy, c, f, m, len, lo, hi, mid2;
            logic [127:0]     sq;
            logic signed [63:0] dlat, dlon, mid, cw, ccw, off, step, hd;
            logic             s;
            s = 1'b0;
            dlat = 64'(w.elat) - 64'(w.slat);
            dlon = 64'(w.elon) - 64'(w.slon);
            alat = dlat < 0 ? -dlat : dlat;
            alon = dlon < 0 ? -dlon : dlon;
            if (w.met) begin
                mid = 64'(w.slat) / 2 + 64'(w.elat) / 2;
                c  = cos_q24(mid);
                dy = (alat * scale) >> 24;
                dx = (((alon * scale) >> 24) * c) >> 24;
            end else begin
                dy = alat << 8;
                dx = alon << 8;
            end
            sq = 128'(dx) * dx + 128'(dy) * dy;
            lo = 0;
            hi = 64'h7FF_FFFF_FFFF;
            while (lo < hi) begin
                mid2 = (lo + hi + 1) >> 1;
                if (128'(mid2) * mid2 <= sq) lo = mid2;
                else hi = mid2 - 1;
            end
            len = lo;
            f = 0;
            if (len != 0) begin
                f = (64'(w.trav) << 32) / len;
                if (f > 64'hFFFF_FFFF_FFFF) begin
                    f = 64'hFFFF_FFFF_FFFF;
                    s = 1'b1;
                end
            end
            o.lat = lerp(w.slat, w.elat, f, s);
            o.lon = lerp(w.slon, w.elon, f, s);
            cw = 0;
            ccw = 0;
            if (w.ha < w.hb) begin
                cw = 64'(w.hb) - w.ha;
                ccw = 46080 - 64'(w.hb) + w.ha;
            end else if (w.ha > w.hb) begin
                cw = 46080 - 64'(w.ha) + w.hb;
                ccw = 64'(w.ha) - w.hb;
            end
            off = (cw < ccw) ? cw : -ccw;
            m = f * 64'(off < 0 ? -off : off);
            if (off >= 0) step = (m + 64'h8000_0000) >> 32;
            else step = -64'((m + 64'h7FFF_FFFF) >> 32);
            hd = 64'(w.ha) + step;
            if (hd > 46080) hd -= 46080;
            else if (hd < 0) hd += 46080;
            begin
                logic ign;
                ign = 1'b0;
                o.hd = sat32(128'(hd), ign);
            end
            o.sat = s;
            return o;
        endfunction

        function void note_input(seg_t w);
            pending.push_back(predict(w));
        endfunction

        function void check_result(interp_t r);
            interp_t e;
            seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, r);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r.lat !== e.lat) begin
                $display("%0t: pos_lat exp %0d got %0d", $time, e.lat, r.lat);
                errors++;
            end
            if (r.lon !== e.lon) begin
                $display("%0t: pos_lon exp %0d got %0d", $time, e.lon, r.lon);
                errors++;
            end
            if (r.hd !== e.hd) begin
                $display("%0t: heading exp %0d got %0d", $time, e.hd, r.hd);
                errors++;
            end
            if (r.sat !== e.sat) begin
                $display("%0t: saturated exp %0b got %0b", $time, e.sat, r.sat);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk, i_rst_n;
    logic               i_cfg_valid, o_cfg_ready;
    logic [31:0]        i_cfg_data;
    logic               i_valid, o_stall, o_valid, i_stall;
    seg_t               drv;
    logic signed [31:0] o_pos_lat, o_pos_lon, o_heading;
    logic               o_saturated;

    interp_scoreboard sb;
    int  idle_cycles;
    bit  stim_done;
    int  accepted;

    segment_position_heading_interpolator_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_start_lat(drv.slat), .i_start_lon(drv.slon),
        .i_end_lat(drv.elat), .i_end_lon(drv.elon),
        .i_start_heading(drv.ha), .i_end_heading(drv.hb),
        .i_travelled(drv.trav), .i_to_metres(drv.met),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_pos_lat(o_pos_lat), .o_pos_lon(o_pos_lon),
        .o_heading(o_heading), .o_saturated(o_saturated)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // receiver: random stall, check on accept
    int stall_left;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_result('{o_pos_lat, o_pos_lon, o_heading, o_saturated});
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (o_valid && !i_stall) stall_left = ($urandom_range(0, 3) == 0) ? 0
                                                 : $urandom_range(0, 7);
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WD_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic release_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic send_segment(seg_t w);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        drv     <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(w);
        accepted++;
    endtask

    task automatic write_scale(logic [31:0] v);
        release_input();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.scale = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 4000) - 2000;
            2: return 32'h7FFF_FFFF - $urandom_range(0, 1000);
            default: return 32'h8000_0000 + $urandom_range(0, 1000);
        endcase
    endfunction

    function automatic seg_t rand_seg();
        seg_t w;
        w.slat = rand_coord();
        w.slon = rand_coord();
        if ($urandom_range(0, 1)) begin
            w.elat = w.slat + $signed($urandom_range(0, 2000000)) - 1000000;
            w.elon = w.slon + $signed($urandom_range(0, 2000000)) - 1000000;
        end else begin
            w.elat = rand_coord();
            w.elon = rand_coord();
        end
        w.ha = ($urandom_range(0, 15) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 46080));
        w.hb = ($urandom_range(0, 15) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 46080));
        case ($urandom_range(0, 3))
            0: w.trav = $urandom();
            1: w.trav = $urandom_range(0, 65535);
            default: w.trav = $urandom_range(0, 1 << 28);
        endcase
        w.met = $urandom_range(0, 1);
        return w;
    endfunction

    task automatic run_random(int n);
        repeat (n) send_segment(rand_seg());
    endtask

    initial begin
        seg_t w;
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        drv = '0;
        idle_cycles = 0;
        accepted = 0;
        stim_done = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero length, fraction overflow, ties and wraps
        send_segment('{0, 0, 0, 0, 0, 0, 0, 1'b0});
        send_segment('{0, 0, 0, 0, 100, 200, 32'hFFFF_FFFF, 1'b1});
        send_segment('{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                       0, 46080, 32'hFFFF_FFFF, 1'b0});
        send_segment('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                       46080, 0, 32'h100, 1'b1});
        send_segment('{0, 0, 1000, 0, 0, 23040, 32'd128000, 1'b0});
        send_segment('{0, 0, 1000, 0, 23040, 0, 32'd128000, 1'b0});
        send_segment('{0, 0, 0, 1000, 46000, 100, 32'd256000, 1'b0});
        send_segment('{0, 0, 0, 1000, 100, 46000, 32'd256000, 1'b0});
        send_segment('{0, 0, -1000, -1000, 16'hFFFF, 16'h0, 32'd1000000, 1'b0});
        send_segment('{0, 0, 5, 5, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0});
        send_segment('{32'sh4000_0000, 0, 32'sh4000_0000, 1000000, 0, 10, 32'd5000, 1'b1});
        send_segment('{32'shC000_0000, 0, 32'shC000_0000, 1000000, 0, 10, 32'd5000, 1'b1});
        send_segment('{0, 0, 3, -3, 300, 400, 32'd2, 1'b1});
        send_segment('{-7, 9, 7, -9, 45000, 1000, 32'd700, 1'b0});
        w = '{32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1};
        send_segment(w);

        run_random(N_RAND / 3);
        write_scale(32'd0);
        send_segment('{0, 0, 1000, 1000, 0, 5, 32'd10, 1'b1});
        run_random(N_RAND / 6);
        write_scale(32'hFFFF_FFFF);
        run_random(N_RAND / 6);
        write_scale($urandom());
        run_random(N_RAND / 6);
        write_scale(32'd1);
        run_random(N_RAND / 6);
        release_input();

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d segment words over five scale settings; %0d results checked.",
                 accepted, sb.seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: segment_position_heading_interpolator_core.f
rtl/sphi_pkg.sv
rtl/segment_position_heading_interpolator_core.sv
bench/segment_position_heading_interpolator_core_tb.sv
